// File: hw/rtl/assert_macros.svh
// Assertion helpers. Both expect i_clk and i_rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RAV_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RAV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rav_pkg.sv
`timescale 1ns / 1ps
package rav_pkg;

    localparam logic [7:0]  RA_TYPE         = 8'd134;
    localparam logic [7:0]  HOP_LIMIT_REQ   = 8'd255;
    localparam logic [15:0] NEXT_HDR_ICMPV6 = 16'd58;
    localparam logic [15:0] CSUM_GOOD       = 16'hffff;
    localparam logic [9:0]  LL_PREFIX       = 10'h3fa;   // fe80::/10
    localparam int          HDR_BYTES       = 16;
    localparam int          MAX_OPT_STEP    = 2040;      // 255 units of 8 bytes
    localparam int          SEED_W          = 21;        // 17 words of 16 bits

    typedef logic [3:0] t_status;

    localparam t_status ST_OK          = 4'd0;
    localparam t_status ST_NOT_LL      = 4'd1;
    localparam t_status ST_HOP         = 4'd2;
    localparam t_status ST_INTERFACE   = 4'd3;
    localparam t_status ST_CHECKSUM    = 4'd4;
    localparam t_status ST_SHORT       = 4'd5;
    localparam t_status ST_TYPE        = 4'd6;
    localparam t_status ST_CODE        = 4'd7;
    localparam t_status ST_ZERO_OPT    = 4'd8;
    localparam t_status ST_OPT_OVERRUN = 4'd9;
    localparam t_status ST_TRAILING    = 4'd10;
    localparam t_status ST_TOO_LONG    = 4'd11;

    // Per-packet metadata sampled on the first byte.
    typedef struct packed {
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [7:0]  hop;
        logic [15:0] ifx;
        logic [31:0] secs;
    } t_meta;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last;
        t_meta      meta;
    } t_item;

    typedef struct packed {
        logic too_long;
        logic opt_zero;
    } t_pkt_flags;

    typedef struct packed {
        t_status     status;
        logic [63:0] router_addr_hi;
        logic [63:0] router_addr_lo;
        logic [15:0] router_interface;
        logic [15:0] router_lifetime;
        logic [31:0] reachable_time;
        logic [31:0] retransmit_time;
        logic [32:0] expiry_seconds;
    } t_result;

    // One's-complement add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// File: hw/rtl/rav_if.sv
`timescale 1ns / 1ps

interface rav_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [7:0]  hop_count_in;
    logic [15:0] rx_interface;
    logic [31:0] rx_seconds;

    modport source (
        output valid, data_byte, first, last, src_addr_hi, src_addr_lo,
               dst_addr_hi, dst_addr_lo, hop_count_in, rx_interface, rx_seconds,
        input  ready
    );
    modport sink (
        input  valid, data_byte, first, last, src_addr_hi, src_addr_lo,
               dst_addr_hi, dst_addr_lo, hop_count_in, rx_interface, rx_seconds,
        output ready
    );
endinterface

interface rav_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [63:0] router_addr_hi;
    logic [63:0] router_addr_lo;
    logic [15:0] router_interface;
    logic [15:0] router_lifetime;
    logic [31:0] reachable_time;
    logic [31:0] retransmit_time;
    logic [32:0] expiry_seconds;

    modport source (
        output valid, status, router_addr_hi, router_addr_lo, router_interface,
               router_lifetime, reachable_time, retransmit_time, expiry_seconds,
        input  ready
    );
    modport sink (
        input  valid, status, router_addr_hi, router_addr_lo, router_interface,
               router_lifetime, reachable_time, retransmit_time, expiry_seconds,
        output ready
    );
endinterface

interface rav_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] accept_interface;

    modport source (output valid, accept_interface, input ready);
    modport sink (input valid, accept_interface, output ready);
endinterface

// File: hw/rtl/rav_parse.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rav_parse #(
    parameter int MAX_PACKET_BYTES = 256,
    parameter int OFF_W            = 9,
    parameter int NOS_W            = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_first,
    input  logic                 i_last,
    input  rav_pkg::t_meta       i_meta,
    input  logic [16:0]          i_seed,
    output logic [OFF_W-1:0]     o_len,
    output logic [15:0]          o_sum,
    output logic [7:0]           o_held,
    output logic [NOS_W-1:0]     o_nos,
    output rav_pkg::t_pkt_flags  o_flags,
    output logic [127:0]         o_hdr,
    output rav_pkg::t_meta       o_meta
);
    import rav_pkg::*;

    logic [OFF_W-1:0] r_off,  n_off,  b_off;
    logic [15:0]      r_sum,  n_sum;
    logic [7:0]       r_held, n_held, b_held;
    logic [NOS_W-1:0] r_nos,  n_nos,  b_nos;
    t_pkt_flags       r_flags, n_flags, b_flags;
    logic [127:0]     r_hdr,  n_hdr,  b_hdr;
    t_meta            r_meta, n_meta;
    logic [15:0]      seed16;

    // Second fold of the pseudo-header sum; cannot carry out again.
    assign seed16 = i_seed[15:0] + {15'd0, i_seed[16]};

    always_comb begin
        // A first byte starts from a cleared packet.
        b_off   = i_first ? '0 : r_off;
        b_held  = i_first ? 8'd0 : r_held;
        b_nos   = i_first ? NOS_W'(HDR_BYTES) : r_nos;
        b_flags = i_first ? '0 : r_flags;
        b_hdr   = i_first ? '0 : r_hdr;

        n_off   = b_off;
        n_sum   = i_first ? seed16 : r_sum;
        n_held  = b_held;
        n_nos   = b_nos;
        n_flags = b_flags;
        n_hdr   = b_hdr;
        n_meta  = i_first ? i_meta : r_meta;

        if (b_off < OFF_W'(MAX_PACKET_BYTES)) begin
            if (b_off < OFF_W'(HDR_BYTES)) begin
                n_hdr[{~b_off[3:0], 3'b000} +: 8] = i_data_byte;
            end
            if (!b_off[0]) begin
                n_held = i_data_byte;
            end else begin
                // odd offset never coincides with a first byte
                n_sum = oc_add(r_sum, {b_held, i_data_byte});
            end
            // option length byte sits one past the option start
            if (!b_flags.opt_zero && b_off >= OFF_W'(HDR_BYTES) &&
                ((NOS_W+1)'(b_nos) + (NOS_W+1)'(1)) == (NOS_W+1)'(b_off)) begin
                if (i_data_byte == 8'd0) begin
                    n_flags.opt_zero = 1'b1;
                end else begin
                    n_nos = b_nos + NOS_W'({i_data_byte, 3'b000});
                end
            end
            n_off = b_off + OFF_W'(1);
        end else begin
            n_flags.too_long = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_sum   <= '0;
            r_held  <= '0;
            r_nos   <= NOS_W'(HDR_BYTES);
            r_flags <= '0;
            r_hdr   <= '0;
            r_meta  <= '0;
        end else if (i_step) begin
            r_meta <= n_meta;
            if (i_last) begin
                r_off   <= '0;
                r_sum   <= '0;
                r_held  <= '0;
                r_nos   <= NOS_W'(HDR_BYTES);
                r_flags <= '0;
                r_hdr   <= '0;
            end else begin
                r_off   <= n_off;
                r_sum   <= n_sum;
                r_held  <= n_held;
                r_nos   <= n_nos;
                r_flags <= n_flags;
                r_hdr   <= n_hdr;
            end
        end
    end

    assign o_len   = n_off;
    assign o_sum   = n_sum;
    assign o_held  = n_held;
    assign o_nos   = n_nos;
    assign o_flags = n_flags;
    assign o_hdr   = n_hdr;
    assign o_meta  = n_meta;

    `RAV_ASSERT_NEXT(a_close_clears, i_step && i_last, r_off == '0 && r_sum == 16'd0, "packet state not cleared after last byte")
    `RAV_ASSERT(a_opt_floor, 1'b1, r_nos >= NOS_W'(HDR_BYTES), "option start below header end")

endmodule

// File: hw/rtl/rav_verdict.sv
`timescale 1ns / 1ps

module rav_verdict #(
    parameter int OFF_W = 9,
    parameter int NOS_W = 12
) (
    input  logic [OFF_W-1:0]     i_len,
    input  logic [15:0]          i_sum,
    input  logic [7:0]           i_held,
    input  logic [NOS_W-1:0]     i_nos,
    input  rav_pkg::t_pkt_flags  i_flags,
    input  logic [127:0]         i_hdr,
    input  rav_pkg::t_meta       i_meta,
    input  logic [15:0]          i_accept_if,
    output rav_pkg::t_result     o_result
);
    import rav_pkg::*;

    logic [17:0]      csum_total;
    logic [16:0]      csum_f1;
    logic [15:0]      csum;
    logic [NOS_W-1:0] len_x;
    t_status          status;

    // Odd tail byte padded, then the 32-bit length (upper half always zero).
    assign csum_total = 18'(i_sum) + (i_len[0] ? 18'({i_held, 8'h00}) : 18'd0) + 18'(i_len);
    assign csum_f1    = 17'(csum_total[15:0]) + 17'(csum_total[17:16]);
    assign csum       = csum_f1[15:0] + {15'd0, csum_f1[16]};
    assign len_x      = NOS_W'(i_len);

    always_comb begin
        if (i_meta.src_hi[63:54] != LL_PREFIX) begin
            status = ST_NOT_LL;
        end else if (i_meta.hop != HOP_LIMIT_REQ) begin
            status = ST_HOP;
        end else if (i_accept_if != 16'd0 && i_meta.ifx != i_accept_if) begin
            status = ST_INTERFACE;
        end else if (i_flags.too_long) begin
            status = ST_TOO_LONG;
        end else if (csum != CSUM_GOOD) begin
            status = ST_CHECKSUM;
        end else if (i_len < OFF_W'(HDR_BYTES)) begin
            status = ST_SHORT;
        end else if (i_hdr[127:120] != RA_TYPE) begin
            status = ST_TYPE;
        end else if (i_hdr[119:112] != 8'd0) begin
            status = ST_CODE;
        end else if (i_flags.opt_zero) begin
            status = ST_ZERO_OPT;
        end else if (i_nos > len_x) begin
            status = ST_OPT_OVERRUN;
        end else if (i_nos < len_x) begin
            status = ST_TRAILING;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_result.status           = status;
        o_result.router_addr_hi   = i_meta.src_hi;
        o_result.router_addr_lo   = i_meta.src_lo;
        o_result.router_interface = i_meta.ifx;
        o_result.router_lifetime  = i_hdr[79:64];
        o_result.reachable_time   = i_hdr[63:32];
        o_result.retransmit_time  = i_hdr[31:0];
        o_result.expiry_seconds   = 33'(i_meta.secs) + 33'(i_hdr[79:64]);
    end

endmodule

// File: hw/rtl/router_advert_validator.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ICMPv6 router advertisement validator.
// i_item carries one message byte per word with first/last marks; the word
// with first also carries source/destination address, hop limit, interface
// and receive time. o_result gives one verdict word per message, on the last
// byte: status code plus router address, interface, lifetime, reachable and
// retransmit times and the expiry time (receive seconds + lifetime).
// i_cfg writes accept_interface (0 = any); it is always ready and should only
// be written while no message is in flight.
// Throughput: one byte per cycle, back to back, across message boundaries,
// while ready is high. The last byte goes through the input register, the
// parse step into the snapshot register and the verdict into the output
// register. The pseudo-header sum is pre-added on the input side.
// Stall: the output register holds until taken; the snapshot register keeps
// the next message's verdict, so bytes keep flowing until a second last byte
// would need that slot, then ready drops.
// Reset (sync, active low) empties the pipeline, clears packet state, sampled
// metadata and accept_interface. Bytes past MAX_PACKET_BYTES are dropped and
// only flag the message too long.
module router_advert_validator #(
    parameter int MAX_PACKET_BYTES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rav_in_if.sink    i_item,
    rav_out_if.source o_result,
    rav_cfg_if.sink   i_cfg
);
    import rav_pkg::*;

    localparam int OFF_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int NOS_W = $clog2(MAX_PACKET_BYTES + MAX_OPT_STEP);

    // config
    logic [15:0] r_accept_if;

    // input register
    logic        r_p1_v;
    t_item       r_p1;
    logic [16:0] r_p1_seed;
    t_item       in_item;
    logic [SEED_W-1:0] seed_total;
    logic [16:0] seed_f1;

    // snapshot register
    logic             r_p2_v;
    logic [OFF_W-1:0] r_p2_len;
    logic [15:0]      r_p2_sum;
    logic [7:0]       r_p2_held;
    logic [NOS_W-1:0] r_p2_nos;
    t_pkt_flags       r_p2_flags;
    logic [127:0]     r_p2_hdr;
    t_meta            r_p2_meta;

    // output register
    logic    r_out_v;
    t_result r_out;

    // parse outputs
    logic [OFF_W-1:0] ps_len;
    logic [15:0]      ps_sum;
    logic [7:0]       ps_held;
    logic [NOS_W-1:0] ps_nos;
    t_pkt_flags       ps_flags;
    logic [127:0]     ps_hdr;
    t_meta            ps_meta;
    t_result          verdict;

    logic in_take, p1_go, p2_go, p2_free, out_free;

    // pipeline handshake
    assign out_free = !r_out_v || o_result.ready;
    assign p2_go    = r_p2_v && out_free;
    assign p2_free  = !r_p2_v || p2_go;
    assign p1_go    = r_p1_v && (!r_p1.last || p2_free);
    assign i_item.ready = !r_p1_v || p1_go;
    assign in_take  = i_item.valid && i_item.ready;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        in_item.data_byte = i_item.data_byte;
        in_item.first     = i_item.first;
        in_item.last      = i_item.last;
        in_item.meta.src_hi = i_item.src_addr_hi;
        in_item.meta.src_lo = i_item.src_addr_lo;
        in_item.meta.hop    = i_item.hop_count_in;
        in_item.meta.ifx    = i_item.rx_interface;
        in_item.meta.secs   = i_item.rx_seconds;
    end

    // Pseudo-header: 16 address words plus next header, folded once here.
    always_comb begin
        seed_total = SEED_W'(NEXT_HDR_ICMPV6);
        for (int k = 0; k < 4; k++) begin
            seed_total = seed_total
                       + SEED_W'(i_item.src_addr_hi[16*k +: 16])
                       + SEED_W'(i_item.src_addr_lo[16*k +: 16])
                       + SEED_W'(i_item.dst_addr_hi[16*k +: 16])
                       + SEED_W'(i_item.dst_addr_lo[16*k +: 16]);
        end
        seed_f1 = 17'(seed_total[15:0]) + 17'(seed_total[SEED_W-1:16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_if <= '0;
        end else if (i_cfg.valid) begin
            r_accept_if <= i_cfg.accept_interface;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (in_take) begin
            r_p1_v <= 1'b1;
        end else if (p1_go) begin
            r_p1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_p1      <= in_item;
            r_p1_seed <= seed_f1;
        end
    end

    rav_parse #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .OFF_W            (OFF_W),
        .NOS_W            (NOS_W)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (p1_go),
        .i_data_byte (r_p1.data_byte),
        .i_first     (r_p1.first),
        .i_last      (r_p1.last),
        .i_meta      (r_p1.meta),
        .i_seed      (r_p1_seed),
        .o_len       (ps_len),
        .o_sum       (ps_sum),
        .o_held      (ps_held),
        .o_nos       (ps_nos),
        .o_flags     (ps_flags),
        .o_hdr       (ps_hdr),
        .o_meta      (ps_meta)
    );

    // Snapshot of the closed message, taken on the last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (p1_go && r_p1.last) begin
            r_p2_v <= 1'b1;
        end else if (p2_go) begin
            r_p2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_go && r_p1.last) begin
            r_p2_len   <= ps_len;
            r_p2_sum   <= ps_sum;
            r_p2_held  <= ps_held;
            r_p2_nos   <= ps_nos;
            r_p2_flags <= ps_flags;
            r_p2_hdr   <= ps_hdr;
            r_p2_meta  <= ps_meta;
        end
    end

    rav_verdict #(
        .OFF_W (OFF_W),
        .NOS_W (NOS_W)
    ) u_verdict (
        .i_len       (r_p2_len),
        .i_sum       (r_p2_sum),
        .i_held      (r_p2_held),
        .i_nos       (r_p2_nos),
        .i_flags     (r_p2_flags),
        .i_hdr       (r_p2_hdr),
        .i_meta      (r_p2_meta),
        .i_accept_if (r_accept_if),
        .o_result    (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (p2_go) begin
            r_out_v <= 1'b1;
        end else if (o_result.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p2_go) begin
            r_out <= verdict;
        end
    end

    assign o_result.valid            = r_out_v;
    assign o_result.status           = r_out.status;
    assign o_result.router_addr_hi   = r_out.router_addr_hi;
    assign o_result.router_addr_lo   = r_out.router_addr_lo;
    assign o_result.router_interface = r_out.router_interface;
    assign o_result.router_lifetime  = r_out.router_lifetime;
    assign o_result.reachable_time   = r_out.reachable_time;
    assign o_result.retransmit_time  = r_out.retransmit_time;
    assign o_result.expiry_seconds   = r_out.expiry_seconds;

    `RAV_ASSERT_NEXT(a_snap_kept, r_p2_v && !p2_go, r_p2_v, "pending verdict snapshot dropped")
    `RAV_ASSERT(a_out_from_snap, $rose(r_out_v), $past(r_p2_v), "verdict without a closed message")

endmodule

// File: dv/router_advert_validator_test.sv
`timescale 1ns / 1ps

module router_advert_validator_test;
    import rav_pkg::*;

    localparam int MAX_BYTES     = 256;     // DUT buffer size, bytes past it are dropped
    localparam int CYCLE_LIMIT   = 200000;  // far above the slowest legal run
    localparam int SETTLE_CYCLES = 10;      // extra wait after the last owed verdict
    localparam int PHASE_BYTES   = 225;

    // Metadata that rides on the first word of a message.
    typedef struct {
        bit [63:0] src_hi;
        bit [63:0] src_lo;
        bit [63:0] dst_hi;
        bit [63:0] dst_lo;
        bit [7:0]  hop;
        bit [15:0] ifx;
        bit [31:0] secs;
    } t_pkt_meta;

    // One input word: a message byte, its marks and the (maybe ignored) metadata.
    typedef struct {
        bit [7:0]  data;
        bit        first;
        bit        last;
        t_pkt_meta meta;
    } t_byte_word;

    // Defects that the generator can build into an otherwise clean advertisement.
    typedef enum int {
        FT_NONE, FT_NOT_LL, FT_HOP, FT_IFX, FT_CSUM, FT_SHORT, FT_TYPE,
        FT_CODE, FT_ZERO_OPT, FT_OVERRUN, FT_TRAILING, FT_TOO_LONG
    } t_fault;

    // ------------------------------------------------------------------
    // Verdict scoreboard: mirrors the validator byte by byte and keeps the
    // verdicts it owes, oldest first.
    // ------------------------------------------------------------------
    class verdict_board;
        // per-message parse state
        int unsigned offset;
        bit [15:0]   csum;
        bit [7:0]    held;
        int unsigned next_opt;
        t_status     first_err;
        bit          too_long;
        bit [7:0]    hdr[16];
        // metadata of the last first-marked word
        bit [63:0]   m_src_hi;
        bit [63:0]   m_src_lo;
        bit [7:0]    m_hop;
        bit [15:0]   m_ifx;
        bit [31:0]   m_secs;
        bit [15:0]   accept_ifx;

        t_result     expected_verdicts[$];
        int          errors;
        int          bytes_seen;
        int          predicted;
        int          checked;
        int          status_seen[16];

        function new();
            clear_packet();
            m_src_hi   = '0;
            m_src_lo   = '0;
            m_hop      = '0;
            m_ifx      = '0;
            m_secs     = '0;
            accept_ifx = '0;
        endfunction

        static function bit [15:0] ones_add(bit [15:0] a, bit [15:0] b);
            bit [16:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'd0, s[16]};
        endfunction

        static function bit [15:0] add_words64(bit [15:0] acc, bit [63:0] w);
            acc = ones_add(acc, w[63:48]);
            acc = ones_add(acc, w[47:32]);
            acc = ones_add(acc, w[31:16]);
            return ones_add(acc, w[15:0]);
        endfunction

        function void clear_packet();
            offset    = 0;
            csum      = '0;
            held      = '0;
            next_opt  = 16;
            first_err = ST_OK;
            too_long  = 1'b0;
            foreach (hdr[i]) hdr[i] = '0;
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        // Feed one accepted word; a last mark closes the message into a verdict.
        function void absorb_byte(t_byte_word w);
            bit [15:0] s;
            bit [15:0] life;
            t_status   st;
            t_result   v;
            bytes_seen++;
            if (w.first) begin
                clear_packet();
                s = 16'h0;
                s = add_words64(s, w.meta.src_hi);
                s = add_words64(s, w.meta.src_lo);
                s = add_words64(s, w.meta.dst_hi);
                s = add_words64(s, w.meta.dst_lo);
                csum     = ones_add(s, NEXT_HDR_ICMPV6);
                m_src_hi = w.meta.src_hi;
                m_src_lo = w.meta.src_lo;
                m_hop    = w.meta.hop;
                m_ifx    = w.meta.ifx;
                m_secs   = w.meta.secs;
            end
            if (offset < MAX_BYTES) begin
                if (offset < HDR_BYTES) hdr[offset] = w.data;
                if (offset % 2 == 0) held = w.data;
                else csum = ones_add(csum, {held, w.data});
                // option walk: the length byte sits one past each option start
                if (first_err == ST_OK && offset >= HDR_BYTES && offset == next_opt + 1) begin
                    if (w.data == 8'h00) first_err = ST_ZERO_OPT;
                    else next_opt += w.data * 8;
                end
                offset++;
            end else begin
                too_long = 1'b1;
            end
            if (!w.last) return;

            s = csum;
            if (offset % 2 == 1) s = ones_add(s, {held, 8'h00});
            s = ones_add(s, 16'(offset >> 16));
            s = ones_add(s, 16'(offset));
            life = {hdr[6], hdr[7]};

            if (m_src_hi[63:54] != LL_PREFIX)                 st = ST_NOT_LL;
            else if (m_hop != HOP_LIMIT_REQ)                  st = ST_HOP;
            else if (accept_ifx != 0 && m_ifx != accept_ifx)  st = ST_INTERFACE;
            else if (too_long)                                st = ST_TOO_LONG;
            else if (s != CSUM_GOOD)                          st = ST_CHECKSUM;
            else if (offset < HDR_BYTES)                      st = ST_SHORT;
            else if (hdr[0] != RA_TYPE)                       st = ST_TYPE;
            else if (hdr[1] != 8'h00)                         st = ST_CODE;
            else if (first_err != ST_OK)                      st = first_err;
            else if (next_opt > offset)                       st = ST_OPT_OVERRUN;
            else if (next_opt < offset)                       st = ST_TRAILING;
            else                                              st = ST_OK;

            v.status           = st;
            v.router_addr_hi   = m_src_hi;
            v.router_addr_lo   = m_src_lo;
            v.router_interface = m_ifx;
            v.router_lifetime  = life;
            v.reachable_time   = {hdr[8], hdr[9], hdr[10], hdr[11]};
            v.retransmit_time  = {hdr[12], hdr[13], hdr[14], hdr[15]};
            v.expiry_seconds   = {1'b0, m_secs} + {17'd0, life};
            expected_verdicts.push_back(v);
            predicted++;
            clear_packet();
        endfunction

        function void mismatch(string field, bit [63:0] want, logic [63:0] got);
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
        endfunction

        function void check_verdict(t_result got);
            t_result want;
            if (expected_verdicts.size() == 0) begin
                errors++;
                $display("%0t: unexpected verdict, status 0x%0h", $time, got.status);
                return;
            end
            want = expected_verdicts.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got.status !== want.status)
                mismatch("status", want.status, got.status);
            if (got.router_addr_hi !== want.router_addr_hi)
                mismatch("router_addr_hi", want.router_addr_hi, got.router_addr_hi);
            if (got.router_addr_lo !== want.router_addr_lo)
                mismatch("router_addr_lo", want.router_addr_lo, got.router_addr_lo);
            if (got.router_interface !== want.router_interface)
                mismatch("router_interface", want.router_interface, got.router_interface);
            if (got.router_lifetime !== want.router_lifetime)
                mismatch("router_lifetime", want.router_lifetime, got.router_lifetime);
            if (got.reachable_time !== want.reachable_time)
                mismatch("reachable_time", want.reachable_time, got.reachable_time);
            if (got.retransmit_time !== want.retransmit_time)
                mismatch("retransmit_time", want.retransmit_time, got.retransmit_time);
            if (got.expiry_seconds !== want.expiry_seconds)
                mismatch("expiry_seconds", want.expiry_seconds, got.expiry_seconds);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic clk;
    logic rst_n;
    bit   steady;        // when set neither side idles
    int   cycle_count;

    rav_in_if  item_if ();
    rav_out_if verdict_if ();
    rav_cfg_if cfg_if ();

    verdict_board sb = new();

    router_advert_validator #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if.sink),
        .o_result (verdict_if.source),
        .i_cfg    (cfg_if.sink)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Result side back-pressure, changed on the falling edge like every input.
    always @(negedge clk) begin
        verdict_if.ready <= steady ? 1'b1 : ($urandom_range(99) >= 23);
    end

    // Verdict monitor: values sampled at the rising edge, before the DUT updates.
    always @(posedge clk) begin
        t_result got;
        if (rst_n && verdict_if.valid && verdict_if.ready) begin
            got.status           = verdict_if.status;
            got.router_addr_hi   = verdict_if.router_addr_hi;
            got.router_addr_lo   = verdict_if.router_addr_lo;
            got.router_interface = verdict_if.router_interface;
            got.router_lifetime  = verdict_if.router_lifetime;
            got.reachable_time   = verdict_if.reachable_time;
            got.retransmit_time  = verdict_if.retransmit_time;
            got.expiry_seconds   = verdict_if.expiry_seconds;
            sb.check_verdict(got);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_pkt_meta random_meta();
        t_pkt_meta m;
        m.src_hi = {$urandom, $urandom};
        m.src_lo = {$urandom, $urandom};
        m.dst_hi = {$urandom, $urandom};
        m.dst_lo = {$urandom, $urandom};
        m.hop    = 8'($urandom);
        m.ifx    = 16'($urandom);
        m.secs   = ($urandom_range(15) == 0) ? 32'hffff_ffff : $urandom;
        return m;
    endfunction

    function automatic void append_option(ref bit [7:0] pkt[$], input int units);
        pkt.push_back(8'($urandom_range(1, 255)));
        pkt.push_back(8'(units));
        repeat (units * 8 - 2) pkt.push_back(8'($urandom));
    endfunction

    // Write the ICMPv6 checksum into bytes 2..3 so the whole message sums to 0xffff.
    function automatic void seal_checksum(ref bit [7:0] pkt[$], input t_pkt_meta m);
        bit [15:0]   s;
        bit [7:0]    lo;
        int unsigned n;
        if (pkt.size() < 4) return;
        pkt[2] = 8'h00;
        pkt[3] = 8'h00;
        s = verdict_board::add_words64(16'h0, m.src_hi);
        s = verdict_board::add_words64(s, m.src_lo);
        s = verdict_board::add_words64(s, m.dst_hi);
        s = verdict_board::add_words64(s, m.dst_lo);
        s = verdict_board::ones_add(s, NEXT_HDR_ICMPV6);
        for (int i = 0; i < pkt.size(); i += 2) begin
            lo = (i + 1 < pkt.size()) ? pkt[i + 1] : 8'h00;
            s  = verdict_board::ones_add(s, {pkt[i], lo});
        end
        n = pkt.size();
        s = verdict_board::ones_add(s, 16'(n >> 16));
        s = verdict_board::ones_add(s, 16'(n));
        {pkt[2], pkt[3]} = ~s;
    endfunction

    // Drive one word; random idle cycles before it unless steady.
    task automatic send_byte(input t_byte_word w);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 23) begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid        <= 1'b1;
        item_if.data_byte    <= w.data;
        item_if.first        <= w.first;
        item_if.last         <= w.last;
        item_if.src_addr_hi  <= w.meta.src_hi;
        item_if.src_addr_lo  <= w.meta.src_lo;
        item_if.dst_addr_hi  <= w.meta.dst_hi;
        item_if.dst_addr_lo  <= w.meta.dst_lo;
        item_if.hop_count_in <= w.meta.hop;
        item_if.rx_interface <= w.meta.ifx;
        item_if.rx_seconds   <= w.meta.secs;
        do @(posedge clk); while (!item_if.ready);
        sb.absorb_byte(w);
    endtask

    // Send a message. Non-first words carry junk metadata that must be ignored.
    // In noisy mode the first/last marks are scrambled inside the message too.
    task automatic send_packet(input bit [7:0] pkt[$], input t_pkt_meta m, input bit noisy);
        t_byte_word w;
        for (int i = 0; i < pkt.size(); i++) begin
            w.data  = pkt[i];
            w.meta  = (i == 0) ? m : random_meta();
            w.first = noisy ? (i == 0 ? $urandom_range(99) < 80 : $urandom_range(99) < 5)
                            : (i == 0);
            w.last  = (i == pkt.size() - 1) || (noisy && $urandom_range(99) < 5);
            send_byte(w);
        end
    endtask

    // Router advertisement with random header and options, one defect at most.
    task automatic send_advert(input t_fault ft);
        bit [7:0]  pkt[$];
        t_pkt_meta m;
        int        units;
        int        target;
        int        pick;
        m = random_meta();
        m.src_hi[63:54] = LL_PREFIX;
        m.hop = HOP_LIMIT_REQ;
        if (sb.accept_ifx != 0) m.ifx = sb.accept_ifx;
        case (ft)
            FT_NOT_LL: m.src_hi[63:54] = LL_PREFIX ^ 10'($urandom_range(1, 1023));
            FT_HOP:    m.hop = HOP_LIMIT_REQ ^ 8'($urandom_range(1, 255));
            FT_IFX:    m.ifx = m.ifx ^ 16'($urandom_range(1, 65535));
            default: ;
        endcase

        pkt.push_back(RA_TYPE);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        repeat (12) pkt.push_back(8'($urandom));
        pick = $urandom_range(9);
        if (pick == 0) {pkt[6], pkt[7]} = 16'h0000;
        if (pick == 1) {pkt[6], pkt[7]} = 16'hffff;
        repeat ($urandom_range(0, 3)) append_option(pkt, $urandom_range(1, 3));

        case (ft)
            FT_TYPE: pkt[0] = RA_TYPE ^ 8'($urandom_range(1, 255));
            FT_CODE: pkt[1] = 8'($urandom_range(1, 255));
            FT_ZERO_OPT: begin
                pkt.push_back(8'($urandom));
                pkt.push_back(8'h00);
                repeat ($urandom_range(0, 8)) pkt.push_back(8'($urandom));
            end
            FT_OVERRUN: begin
                // keep the length byte, cut into the option body
                units = $urandom_range(1, 4);
                append_option(pkt, units);
                repeat ($urandom_range(1, units * 8 - 2)) void'(pkt.pop_back());
            end
            FT_TRAILING: repeat ($urandom_range(1, 7)) pkt.push_back(8'($urandom));
            FT_SHORT: begin
                target = $urandom_range(1, 15);
                while (pkt.size() > target) void'(pkt.pop_back());
            end
            FT_TOO_LONG: begin
                // straddles the buffer size so both sides of the edge are hit
                target = $urandom_range(MAX_BYTES - 6, MAX_BYTES + 44);
                while (pkt.size() < target) append_option(pkt, 8);
                while (pkt.size() > target) void'(pkt.pop_back());
            end
            default: ;
        endcase

        seal_checksum(pkt, m);
        if (ft == FT_CSUM) begin
            pick = $urandom_range(pkt.size() - 1);
            pkt[pick] = pkt[pick] ^ (8'h01 << $urandom_range(7));
        end
        send_packet(pkt, m, 1'b0);
    endtask

    // Short garbage message; source and hop limit are each made plausible half the time.
    task automatic send_noise();
        bit [7:0]  pkt[$];
        t_pkt_meta m;
        m = random_meta();
        if ($urandom_range(1)) m.src_hi[63:54] = LL_PREFIX;
        if ($urandom_range(1)) m.hop = HOP_LIMIT_REQ;
        repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
        send_packet(pkt, m, 1'b1);
    endtask

    // Release the bus and wait until every owed verdict has come back.
    task automatic settle();
        @(negedge clk);
        item_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_accept(input bit [15:0] value);
        @(negedge clk);
        cfg_if.valid            <= 1'b1;
        cfg_if.accept_interface <= value;
        do @(posedge clk); while (!cfg_if.ready);
        sb.accept_ifx = value;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        bit [15:0]  accept_plan[6];
        bit [7:0]   pkt[$];
        t_pkt_meta  m;
        t_byte_word w;
        int         phase_end;
        int         kind;
        string      status_list;

        rst_n                   = 1'b0;
        steady                  = 1'b0;
        item_if.valid           = 1'b0;
        item_if.data_byte       = '0;
        item_if.first           = 1'b0;
        item_if.last            = 1'b0;
        item_if.src_addr_hi     = '0;
        item_if.src_addr_lo     = '0;
        item_if.dst_addr_hi     = '0;
        item_if.dst_addr_lo     = '0;
        item_if.hop_count_in    = '0;
        item_if.rx_interface    = '0;
        item_if.rx_seconds      = '0;
        verdict_if.ready        = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.accept_interface = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed part, accept_interface still at its reset value (any) ---
        // one-byte message, every field at its top value
        w.data  = 8'hff;
        w.first = 1'b1;
        w.last  = 1'b1;
        w.meta  = '{src_hi: '1, src_lo: '1, dst_hi: '1, dst_lo: '1,
                    hop: '1, ifx: '1, secs: '1};
        send_byte(w);
        // lone word with no first mark: empty sum, metadata from before
        w.data  = 8'h00;
        w.first = 1'b0;
        w.meta  = '{src_hi: '0, src_lo: '0, dst_hi: '0, dst_lo: '0,
                    hop: '0, ifx: '0, secs: '0};
        send_byte(w);
        // bare 16-byte advertisement, lifetime and receive time at maximum
        m = '{src_hi: {LL_PREFIX, 54'h0}, src_lo: '1, dst_hi: 64'hff02_0000_0000_0000,
              dst_lo: 64'h1, hop: HOP_LIMIT_REQ, ifx: 16'hffff, secs: '1};
        pkt = '{RA_TYPE, 8'h00, 8'h00, 8'h00, 8'h40, 8'hc0, 8'hff, 8'hff,
                8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00};
        seal_checksum(pkt, m);
        send_packet(pkt, m, 1'b0);
        // two zero bytes with all-zero metadata
        pkt = '{8'h00, 8'h00};
        send_packet(pkt, w.meta, 1'b0);

        // --- random part: one phase per interface filter setting ---
        accept_plan[0] = 16'hffff;
        accept_plan[1] = 16'h0000;
        accept_plan[2] = 16'h0001;
        accept_plan[3] = 16'($urandom_range(2, 65534));
        accept_plan[4] = 16'h0000;
        accept_plan[5] = 16'($urandom);
        for (int p = 0; p < 6; p++) begin
            settle();
            write_accept(accept_plan[p]);
            steady    = (p == 2);   // one long stretch with both sides busy
            phase_end = sb.bytes_seen + PHASE_BYTES;
            while (sb.bytes_seen < phase_end) begin
                kind = $urandom_range(99);
                if (kind < 50)      send_advert(FT_NONE);
                else if (kind < 85) send_advert(t_fault'($urandom_range(1, 11)));
                else                send_noise();
            end
        end
        settle();

        for (int s = 0; s < 12; s++)
            status_list = {status_list, $sformatf(" %0d:%0d", s, sb.status_seen[s])};
        $display("Run covered %0d bytes and %0d verdicts over 7 interface filter settings",
                 sb.bytes_seen, sb.checked);
        $display("Verdicts per status code:%s", status_list);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rav_pkg.sv
hw/rtl/rav_if.sv
hw/rtl/rav_parse.sv
hw/rtl/rav_verdict.sv
hw/rtl/router_advert_validator.sv
dv/router_advert_validator_test.sv
